### hdl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  // replacement character for anything that cannot be decoded
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // closing action of a command after its replacement run
  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_UNIT = 2'd1,
    FIN_END  = 2'd2
  } fin_e;

  // work for the back end caused by one input byte
  typedef struct packed {
    logic [1:0]  rep_cnt;  // number of leading U+FFFD units
    fin_e        fin;      // what follows the replacement run
    logic [15:0] unit;     // value for FIN_UNIT
  } cmd_t;

  // command together with its valid flag, used on both queue sides
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

`default_nettype wire

### hdl/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d interfaces
// Valid/ready channels for input bytes, decoded units and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// utf-8 byte channel
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// decoded utf-16 unit channel
interface u8d_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;
  logic [15:0] unit_count;
  logic        last_of_run;

  modport source (output valid, output code_unit, output end_of_string,
                  output unit_count, output last_of_run, input ready);
  modport sink (input valid, input code_unit, input end_of_string,
                input unit_count, input last_of_run, output ready);
endinterface

// configuration write channel for the unit limit
interface u8d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_units;

  modport source (output valid, output max_units, input ready);
  modport sink (input valid, input max_units, output ready);
endinterface

`default_nettype wire

### hdl/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Accepts utf-8 bytes, tracks the pending sequence and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  u8d_byte_if.sink           in_i,
  input  wire logic          full_i,
  output u8d_pkg::cmd_req_t  push_o
);

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] L2_LO     = 8'hC2;
  localparam logic [7:0] L2_HI     = 8'hDF;
  localparam logic [7:0] L3_LO     = 8'hE0;
  localparam logic [7:0] L3_HI     = 8'hEF;
  localparam logic [7:0] L4_LO     = 8'hF0;
  localparam logic [7:0] L4_HI     = 8'hF4;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] SEC_A0    = 8'hA0;
  localparam logic [7:0] SEC_90    = 8'h90;

  logic [7:0]  lead_q, lead_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  held_q, held_d;
  logic [15:0] part_q, part_d;

  logic            accept;
  logic [7:0]      b;
  logic            ok;
  logic            do_lead;
  u8d_pkg::cmd_t   cmd;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;

  // classify the byte against the pending sequence
  always_comb begin
    lead_d      = lead_q;
    need_d      = need_q;
    held_d      = held_q;
    part_d      = part_q;
    ok          = 1'b0;
    do_lead     = 1'b0;
    cmd.rep_cnt = 2'd0;
    cmd.fin     = u8d_pkg::FIN_NONE;
    cmd.unit    = 16'h0000;

    if (need_q != 2'd0) begin
      ok = ((b & CONT_MASK) == CONT_TAG);
      // range limits on the first continuation byte
      if (held_q == 2'd0) begin
        if (lead_q == L3_LO && b < SEC_A0) ok = 1'b0;
        if (lead_q == LEAD_ED && b >= SEC_A0) ok = 1'b0;
        if (lead_q == L4_LO && b < SEC_90) ok = 1'b0;
        if (lead_q == L4_HI && b >= SEC_90) ok = 1'b0;
      end
      if (ok) begin
        part_d = {part_q[9:0], b[5:0]};
        held_d = held_q + 2'd1;
        need_d = need_q - 2'd1;
        if (need_q == 2'd1) begin
          cmd.fin  = u8d_pkg::FIN_UNIT;
          cmd.unit = (lead_q >= L4_LO) ? u8d_pkg::REPL_UNIT : part_d;
          lead_d   = 8'h00;
          need_d   = 2'd0;
          held_d   = 2'd0;
          part_d   = 16'h0000;
        end
      end else begin
        // broken sequence: lead plus each held byte, then retry as lead
        cmd.rep_cnt = held_q + 2'd1;
        lead_d      = 8'h00;
        need_d      = 2'd0;
        held_d      = 2'd0;
        part_d      = 16'h0000;
        do_lead     = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    // lead byte handling
    if (do_lead) begin
      if (b == 8'h00) begin
        cmd.fin = u8d_pkg::FIN_END;
      end else if (b < ASCII_END) begin
        cmd.fin  = u8d_pkg::FIN_UNIT;
        cmd.unit = {8'h00, b};
      end else if (b inside {[L2_LO:L2_HI]}) begin
        lead_d = b;
        need_d = 2'd1;
        held_d = 2'd0;
        part_d = {11'h000, b[4:0]};
      end else if (b inside {[L3_LO:L3_HI]}) begin
        lead_d = b;
        need_d = 2'd2;
        held_d = 2'd0;
        part_d = {12'h000, b[3:0]};
      end else if (b inside {[L4_LO:L4_HI]}) begin
        lead_d = b;
        need_d = 2'd3;
        held_d = 2'd0;
        part_d = 16'h0000;
      end else begin
        cmd.fin  = u8d_pkg::FIN_UNIT;
        cmd.unit = u8d_pkg::REPL_UNIT;
      end
    end
  end

  // only bytes that produce something reach the queue
  assign push_o.valid = accept && (cmd.rep_cnt != 2'd0 || cmd.fin != u8d_pkg::FIN_NONE);
  assign push_o.cmd   = cmd;

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'h00;
      need_q <= 2'd0;
      held_q <= 2'd0;
      part_q <= 16'h0000;
    end else if (accept) begin
      lead_q <= lead_d;
      need_q <= need_d;
      held_q <= held_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

### hdl/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Small register fifo of commands between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  u8d_pkg::cmd_req_t push_i,
  output logic              full_o,
  output u8d_pkg::cmd_req_t head_o,
  input  wire logic         pop_i
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8d_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Expands queued commands into code units, applies the unit limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [15:0]  max_units_i,
  input  u8d_pkg::cmd_req_t head_i,
  output logic              pop_o,
  u8d_unit_if.source        out_o
);

  logic [15:0] count_q, count_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] code_q, code_d;
  logic        eos_q, eos_d;
  logic [15:0] ucnt_q, ucnt_d;
  logic        last_q, last_d;

  logic        can_go;
  logic        emit;
  logic        has_end;
  logic [2:0]  n_units;
  logic [2:0]  n_total;
  logic [2:0]  idx_ext;
  logic [15:0] cnt_inc;

  assign can_go  = !out_valid_q || out_o.ready;
  assign has_end = (head_i.cmd.fin == u8d_pkg::FIN_END);
  assign n_units = {1'b0, head_i.cmd.rep_cnt} +
                   {2'b00, (head_i.cmd.fin == u8d_pkg::FIN_UNIT)};
  assign n_total = n_units + {2'b00, has_end};
  assign idx_ext = {1'b0, idx_q};
  assign cnt_inc = count_q + 16'd1;

  // one emission of the head command per cycle while the output register can take it
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    code_d  = code_q;
    eos_d   = eos_q;
    ucnt_d  = ucnt_q;
    last_d  = last_q;

    if (head_i.valid && can_go) begin
      if (idx_ext < n_units) begin
        if (count_q < max_units_i) begin
          emit    = 1'b1;
          code_d  = (idx_ext < {1'b0, head_i.cmd.rep_cnt}) ? u8d_pkg::REPL_UNIT
                                                          : head_i.cmd.unit;
          eos_d   = 1'b0;
          count_d = cnt_inc;
          ucnt_d  = cnt_inc;
          // later units of this command would all be dropped at the limit
          last_d  = (idx_ext + 3'd1 == n_total) ||
                    (!has_end && cnt_inc >= max_units_i);
          pop_o   = last_d;
          idx_d   = last_d ? 2'd0 : idx_q + 2'd1;
        end else if (has_end) begin
          // rest of the units dropped, the end item still goes out
          emit    = 1'b1;
          code_d  = 16'h0000;
          eos_d   = 1'b1;
          ucnt_d  = count_q;
          last_d  = 1'b1;
          count_d = 16'd0;
          pop_o   = 1'b1;
          idx_d   = 2'd0;
        end else begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end
      end else begin
        emit    = 1'b1;
        code_d  = 16'h0000;
        eos_d   = 1'b1;
        ucnt_d  = count_q;
        last_d  = 1'b1;
        count_d = 16'd0;
        pop_o   = 1'b1;
        idx_d   = 2'd0;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 16'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    eos_q  <= eos_d;
    ucnt_q <= ucnt_d;
    last_q <= last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_unit     = code_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.unit_count    = ucnt_q;
  assign out_o.last_of_run   = last_q;

endmodule

`default_nettype wire

### hdl/utf8_to_utf16_bmp_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Streaming utf-8 to utf-16 decoder for the basic multilingual plane.
// ----------------------------------------------------------------------------
//
//   channel  modport  payload                                   purpose
//   in_i     sink     data_byte[7:0]                            utf-8 bytes
//   out_o    source   code_unit, end_of_string, unit_count,     decoded units
//                     last_of_run
//   cfg_i    sink     max_units[15:0]                           unit limit
//
// takes one byte per cycle while the command queue has room; each byte yields
// zero to four results, and the single output register sends one result per
// cycle while out_o.ready is high, holding the back end until all are out (a
// fully dropped run sends none); a command queue of QUEUE_DEPTH entries lets
// input continue meanwhile; in_i.ready drops only when that queue is full
// reset clears all control state at once, no clearing pass
// cfg_i is always ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_bmp_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8d_byte_if.sink    in_i,
  u8d_unit_if.source  out_o,
  u8d_cfg_if.sink     cfg_i
);

  logic [15:0]        max_units_q;
  u8d_pkg::cmd_req_t  push;
  u8d_pkg::cmd_req_t  head;
  logic               full;
  logic               pop;

  // unit limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= 16'hFFFF;
    end else if (cfg_i.valid) begin
      max_units_q <= cfg_i.max_units;
    end
  end

  // byte classification
  u8d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  // command queue
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // unit expansion and output
  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_units_i (max_units_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !full)
    else $error("command pushed into full queue");

  // an end item always closes the run of its byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_string |-> out_o.last_of_run && out_o.code_unit == 16'h0000)
    else $error("end item malformed");

  // every emitted unit has been counted
  a_unit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.end_of_string |-> out_o.unit_count != 16'd0)
    else $error("unit emitted with zero count");
`endif

endmodule

`default_nettype wire
